// ----- rtl/base64_stream_encoder_assert.svh -----
// Assertion macros for the Base64 stream encoder.
// Used by the top level only; relies on signals named clock and reset there.
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// Condition in this cycle implies a consequence in the same cycle.
`define B64SE_ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Condition in this cycle implies a consequence in the next cycle.
`define B64SE_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- rtl/b64se_pkg.sv -----
// Shared types, constants and the alphabet function of the Base64 stream encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package b64se_pkg;

   // Input bytes per output line before CR LF is inserted.
   localparam int BYTES_PER_LINE = 57;
   localparam logic [5:0] LINE_LIMIT = 6'(BYTES_PER_LINE);

   // Special characters.
   localparam logic [7:0] CHAR_PAD = 8'h3D;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;

   // Position of a byte within its three-byte group.
   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;

   // Characters produced by one input byte, first character in slot 0.
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [2:0]      count;
      logic            last;
   } burst_type;

   // Maps a six-bit value onto the standard Base64 alphabet.
   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] w;
      logic [7:0] r;
      w = {2'b00, v};
      case (v) inside
         [6'd0:6'd25]:  r = w + 8'd65;
         [6'd26:6'd51]: r = w + 8'd71;
         [6'd52:6'd61]: r = w - 8'd4;
         6'd62:         r = 8'h2B;
         default:       r = 8'h2F;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/base64_stream_encoder.sv -----
// Base64 stream encoder with CR LF after every 57 input bytes and '=' padding of the
// final group. Each accepted byte yields one to four characters, which leave on the
// one-character result port at one per beat while rsp_stall is low; the burst register
// in front of the result port takes the next byte in the cycle in which the previous
// burst's final character is delivered, or whenever it is empty.
// Depends on b64se_pkg, b64se_core, b64se_burst_buf and the assertion header.
`default_nettype none
`include "base64_stream_encoder_assert.svh"

module base64_stream_encoder
   import b64se_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_last_char
);

   logic      req_accept;
   logic      buf_ready;
   burst_type burst;

   assign req_stall  = !buf_ready;
   assign req_accept = req_valid && buf_ready;

   // Encoding core: computes the burst for the current beat.
   b64se_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .burst     (burst)
   );

   // Burst register feeding the result port.
   b64se_burst_buf u_buf (
      .clock         (clock),
      .reset         (reset),
      .load          (req_accept),
      .burst_in      (burst),
      .ready         (buf_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

   // Every accepted byte produces at least one character in the next cycle.
   `B64SE_ASSERT_NEXT(a_accept_gives_rsp, req_accept, rsp_valid, "accepted byte gave no character")

   // A byte is never taken while a held character is stalled.
   `B64SE_ASSERT_SAME(a_no_accept_over_stall, req_accept, !rsp_valid || !rsp_stall, "byte accepted over a stalled character")

   // A final byte always yields more than one character, so its first is not last.
   `B64SE_ASSERT_NEXT(a_final_burst_long, req_accept && req_last_byte, !rsp_last_char, "final burst too short")

endmodule

`default_nettype wire

// ----- rtl/b64se_core.sv -----
// Encoding core: group and line state, and the characters caused by one byte.
// Depends on b64se_pkg.
`default_nettype none

module b64se_core
   import b64se_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] data_byte,
   input  wire logic       last_byte,
   output burst_type       burst
);

   logic [7:0] held_byte_ff, held_byte_in;
   logic [1:0] group_pos_ff, group_pos_in;
   logic [5:0] line_count_ff, line_count_in;
   logic [5:0] line_count_inc;

   assign line_count_inc = line_count_ff + 6'd1;

   // Characters of the current byte and the state it leaves behind.
   always_comb begin
      burst.chars   = '0;
      burst.count   = 3'd1;
      burst.last    = last_byte;
      held_byte_in  = held_byte_ff;
      group_pos_in  = group_pos_ff;
      line_count_in = line_count_ff;
      case (group_pos_ff)
         POS_SECOND: begin
            burst.chars[0] = sextet_char({held_byte_ff[1:0], data_byte[7:4]});
            if (last_byte) begin
               burst.chars[1] = sextet_char({data_byte[3:0], 2'b00});
               burst.chars[2] = CHAR_PAD;
               burst.count    = 3'd3;
            end else begin
               held_byte_in  = data_byte;
               group_pos_in  = POS_THIRD;
               line_count_in = line_count_inc;
            end
         end
         POS_THIRD: begin
            burst.chars[0] = sextet_char({held_byte_ff[3:0], data_byte[7:6]});
            burst.chars[1] = sextet_char(data_byte[5:0]);
            burst.count    = 3'd2;
            line_count_in  = line_count_inc;
            if (line_count_inc >= LINE_LIMIT) begin
               burst.chars[2] = CHAR_CR;
               burst.chars[3] = CHAR_LF;
               burst.count    = 3'd4;
               line_count_in  = '0;
            end
            held_byte_in = '0;
            group_pos_in = POS_FIRST;
         end
         default: begin
            burst.chars[0] = sextet_char(data_byte[7:2]);
            if (last_byte) begin
               burst.chars[1] = sextet_char({data_byte[1:0], 4'b0000});
               burst.chars[2] = CHAR_PAD;
               burst.chars[3] = CHAR_PAD;
               burst.count    = 3'd4;
            end else begin
               held_byte_in  = data_byte;
               group_pos_in  = POS_SECOND;
               line_count_in = line_count_inc;
            end
         end
      endcase
      // The final byte returns the encoder to the start of a fresh line.
      if (last_byte) begin
         held_byte_in  = '0;
         group_pos_in  = POS_FIRST;
         line_count_in = '0;
      end
   end

   // State advances only when a beat is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff  <= '0;
         group_pos_ff  <= POS_FIRST;
         line_count_ff <= '0;
      end else if (accept) begin
         held_byte_ff  <= held_byte_in;
         group_pos_ff  <= group_pos_in;
         line_count_ff <= line_count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/b64se_burst_buf.sv -----
// Result register: holds one burst of up to four characters and emits one per beat while not stalled.
// Depends on b64se_pkg.
`default_nettype none

module b64se_burst_buf
   import b64se_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire burst_type  burst_in,
   output logic            ready,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_last_char
);

   logic [3:0][7:0] chars_ff, chars_in;
   logic [2:0]      remain_ff, remain_in;
   logic [1:0]      index_ff, index_in;
   logic            last_ff, last_in;
   logic            taken;

   assign rsp_valid     = (remain_ff != 3'd0);
   assign taken         = rsp_valid && !rsp_stall;
   assign rsp_out_char  = chars_ff[index_ff];
   assign rsp_last_char = last_ff && (remain_ff == 3'd1);

   // A new burst may enter once the buffer is empty or its final beat leaves.
   assign ready = (remain_ff == 3'd0) || ((remain_ff == 3'd1) && taken);

   // Advance through the burst, or load the next one.
   always_comb begin
      chars_in  = chars_ff;
      remain_in = remain_ff;
      index_in  = index_ff;
      last_in   = last_ff;
      if (taken) begin
         remain_in = remain_ff - 3'd1;
         index_in  = index_ff + 2'd1;
      end
      if (load) begin
         chars_in  = burst_in.chars;
         remain_in = burst_in.count;
         index_in  = '0;
         last_in   = burst_in.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         index_ff  <= '0;
         last_ff   <= 1'b0;
      end else begin
         remain_ff <= remain_in;
         index_ff  <= index_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
   end

endmodule

`default_nettype wire

// ----- sim/tb_base64_stream_encoder.sv -----
// Self-checking testbench for the Base64 stream encoder: drives byte messages, predicts
// every output character with padding and CR LF line breaks, and compares beat by beat.
// Depends on b64se_pkg and the base64_stream_encoder top level.
`default_nettype none

module tb_base64_stream_encoder;
   import b64se_pkg::*;

   localparam int CYCLE_LIMIT = 100000;
   localparam int DRAIN_CYCLES = 8;

   // Standard alphabet, character 0 in the top byte.
   localparam logic [511:0] B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
   } char_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_last_char;

   // Encoder state as the testbench sees it.
   logic [7:0] model_held;
   logic [1:0] model_pos;
   logic [5:0] model_count;

   char_beat_type expected_chars[$];
   char_beat_type oldest_char;
   bit         idle_on = 1'b1;
   int         stall_left = 0;
   int         cycle_count = 0;
   int         fail_count = 0;
   int         chars_checked = 0;
   int         bytes_sent = 0;
   int         messages_sent = 0;
   int         line_breaks = 0;

   base64_stream_encoder uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

   always #4 clock = ~clock;

   function automatic logic [7:0] alphabet_char(input logic [5:0] v);
      int idx;
      idx = 63 - int'(v);
      return B64_ALPHABET[idx*8 +: 8];
   endfunction

   // Works out the characters one byte yields and queues them in order.
   task automatic predict_encoding(input logic [7:0] b, input logic fin);
      logic [7:0]    burst[4];
      logic [5:0]    next_count;
      int            n;
      char_beat_type beat;
      n = 0;
      case (model_pos)
         POS_SECOND: begin
            burst[n++] = alphabet_char({model_held[1:0], b[7:4]});
            if (fin) begin
               burst[n++] = alphabet_char({b[3:0], 2'b00});
               burst[n++] = CHAR_PAD;
            end else begin
               model_held = b;
               model_pos = POS_THIRD;
               model_count = model_count + 6'd1;
            end
         end
         POS_THIRD: begin
            next_count = model_count + 6'd1;
            burst[n++] = alphabet_char({model_held[3:0], b[7:6]});
            burst[n++] = alphabet_char(b[5:0]);
            if (next_count >= LINE_LIMIT) begin
               burst[n++] = CHAR_CR;
               burst[n++] = CHAR_LF;
               next_count = 6'd0;
               line_breaks++;
            end
            model_held = 8'h00;
            model_pos = POS_FIRST;
            model_count = next_count;
         end
         default: begin
            burst[n++] = alphabet_char(b[7:2]);
            if (fin) begin
               burst[n++] = alphabet_char({b[1:0], 4'b0000});
               burst[n++] = CHAR_PAD;
               burst[n++] = CHAR_PAD;
            end else begin
               model_held = b;
               model_pos = POS_SECOND;
               model_count = model_count + 6'd1;
            end
         end
      endcase
      for (int i = 0; i < n; i++) begin
         beat.ch = burst[i];
         beat.fin = fin && (i == n - 1);
         expected_chars = {expected_chars, beat};
      end
      // The final byte of a message returns the encoder to its reset state.
      if (fin) begin
         model_held = 8'h00;
         model_pos = POS_FIRST;
         model_count = 6'd0;
      end
   endtask

   // Sends one byte, with an occasional idle gap before it, and waits for its beat.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      predict_encoding(b, fin);
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= fin;
      do @(posedge clock); while (!(req_valid && !req_stall));
      bytes_sent++;
      if (fin)
         messages_sent++;
   endtask

   // Sends a message given as a right-aligned byte string.
   task automatic send_string(input logic [63:0] text, input int len);
      for (int i = 0; i < len; i++)
         send_byte(text[(len - 1 - i)*8 +: 8], i == len - 1);
   endtask

   task automatic send_random_message(input int len);
      for (int i = 0; i < len; i++)
         send_byte(8'($urandom_range(0, 255)), i == len - 1);
   endtask

   // Holds the sender off until every queued character has been delivered.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0)
         @(posedge clock);
   endtask

   // Short messages: both padding forms, no padding, alphabet extremes.
   task automatic test_padding_and_alphabet();
      send_string(64'h00, 1);
      send_string(64'hFF, 1);
      send_string(64'h00FF, 2);
      send_string(64'hFF00, 2);
      send_string(64'hFBEFBE, 3);
      send_string(64'hFFFFFF, 3);
      send_string({8'h00, "Man", 32'h01020304}, 7);
      send_string("hello", 5);
   endtask

   // A message ending exactly on a line end, then one that runs just past it.
   task automatic test_line_boundaries();
      send_random_message(BYTES_PER_LINE);
      send_random_message(BYTES_PER_LINE + 2);
   endtask

   // Random messages, mostly short, some long enough to cross line ends.
   task automatic test_random_messages();
      int target;
      bit paused;
      target = bytes_sent + 70;
      paused = 1'b0;
      while (bytes_sent < target) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) == 0)
            send_random_message($urandom_range(BYTES_PER_LINE - 3, 2*BYTES_PER_LINE + 4));
         else
            send_random_message($urandom_range(1, 12));
         if (!paused && bytes_sent > target - 50) begin
            wait_for_drain();
            paused = 1'b1;
         end
      end
   endtask

   // Back-to-back messages with neither side idling.
   task automatic test_steady_stream();
      int target;
      idle_on = 1'b0;
      target = bytes_sent + 30;
      while (bytes_sent < target)
         send_random_message($urandom_range(1, 9));
   endtask

   // Result side: random stall bursts.
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Each delivered character is compared with the oldest one expected.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected character %h, last %b", $time, rsp_out_char,
                     rsp_last_char);
            fail_count++;
         end else begin
            oldest_char = expected_chars.pop_front();
            if (rsp_out_char !== oldest_char.ch) begin
               $display("%0t: out_char expected %h, actual %h", $time, oldest_char.ch,
                        rsp_out_char);
               fail_count++;
            end
            if (rsp_last_char !== oldest_char.fin) begin
               $display("%0t: last_char expected %b, actual %b", $time, oldest_char.fin,
                        rsp_last_char);
               fail_count++;
            end
            chars_checked++;
         end
      end
   end

   // Guards against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d characters outstanding", $time,
                  expected_chars.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      model_held = 8'h00;
      model_pos = POS_FIRST;
      model_count = 6'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_padding_and_alphabet();
      test_line_boundaries();
      test_random_messages();
      test_steady_stream();

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Encoded %0d bytes in %0d messages; %0d characters checked.",
               bytes_sent, messages_sent, chars_checked);
      $display("Covered both padding forms, %0d line breaks and random stalls on both sides.",
               line_breaks);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// ----- base64_stream_encoder.f -----
+incdir+rtl
rtl/b64se_pkg.sv
rtl/b64se_core.sv
rtl/b64se_burst_buf.sv
rtl/base64_stream_encoder.sv
sim/tb_base64_stream_encoder.sv
